// ===== design/fibonacci_word_bit_packer_assert.svh =====
// assertion macros for the fibonacci word bit packer
// no dependencies; included by fwbp_engine, the one module that carries assertions
`ifndef FIBONACCI_WORD_BIT_PACKER_ASSERT_SVH
`define FIBONACCI_WORD_BIT_PACKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FWBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwbp assertion failed");

// next-cycle implication, disabled during reset
`define FWBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwbp assertion failed");

`endif

// ===== design/fwbp_pkg.sv =====
// shared constants and types of the fibonacci word bit packer
// no dependencies
package fwbp_pkg;

    localparam int MAX_WORDS = 64;
    // depth counter holds zero to MAX_WORDS
    localparam int DEPTH_W   = $clog2(MAX_WORDS + 1);
    localparam int STACK_AW  = $clog2(MAX_WORDS);
    localparam int WORD_W    = 7;
    localparam int BYTE_BITS = 8;
    localparam int FILL_W    = 4;

    localparam logic [WORD_W-1:0] WORD_COUNT_RESET = 7'd53;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic [FILL_W-1:0]    valid_bits;
        logic                 last;
        logic                 done_res;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FETCH = 3'b100
    } state_t;

endpackage

// ===== design/fwbp_req_queue.sv =====
// front part: two-entry request queue holding the restart flag of each request
// depends on fwbp_pkg only by convention (no shared items used)
module fwbp_req_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic restart,
    output logic full,
    output logic req_valid,
    output logic req_restart,
    input  logic req_take
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       slot0_reg;
    logic       slot1_reg;
    logic       do_push;
    logic       do_pop;

    assign full        = (count_reg == 2'd2);
    assign req_valid   = (count_reg != 2'd0);
    assign req_restart = slot0_reg;
    assign do_push     = push && !full;
    assign do_pop      = req_take && req_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && do_pop)
        begin
            if (count_reg == 2'd1)
            begin
                slot0_reg <= restart;
            end
            else
            begin
                slot0_reg <= slot1_reg;
                slot1_reg <= restart;
            end
        end
        else if (do_push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= restart;
            end
            else
            begin
                slot1_reg <= restart;
            end
        end
        else if (do_pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

// ===== design/fwbp_res_queue.sv =====
// two-entry result queue between the engine and the result ports
// depends on fwbp_pkg for the result struct
module fwbp_res_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_push,
    input  fwbp_pkg::res_t res_in,
    output logic          res_full,
    input  logic          pop,
    output logic          empty,
    output fwbp_pkg::res_t res_out
);

    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    fwbp_pkg::res_t slot0_reg;
    fwbp_pkg::res_t slot1_reg;
    logic           do_push;
    logic           do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign res_out  = slot0_reg;
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && do_pop)
        begin
            if (count_reg == 2'd1)
            begin
                slot0_reg <= res_in;
            end
            else
            begin
                slot0_reg <= slot1_reg;
                slot1_reg <= res_in;
            end
        end
        else if (do_push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= res_in;
            end
            else
            begin
                slot1_reg <= res_in;
            end
        end
        else if (do_pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

// ===== design/fwbp_engine.sv =====
// back part: depth-first word expansion with a stack memory and bit packing
// depends on fwbp_pkg and fibonacci_word_bit_packer_assert.svh
`include "fibonacci_word_bit_packer_assert.svh"

module fwbp_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_restart,
    output logic                        req_take,
    input  logic [fwbp_pkg::WORD_W-1:0] word_count,
    output logic                        res_push,
    output fwbp_pkg::res_t              res_data,
    input  logic                        res_full
);

    localparam int DW = fwbp_pkg::DEPTH_W;
    localparam int AW = fwbp_pkg::STACK_AW;
    localparam int WW = fwbp_pkg::WORD_W;
    localparam int FW = fwbp_pkg::FILL_W;
    localparam int BW = fwbp_pkg::BYTE_BITS;

    fwbp_pkg::state_t state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [WW-1:0] tos_reg, tos_next;
    logic [WW-1:0] word_idx_reg, word_idx_next;
    logic [BW-1:0] acc_reg, acc_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          pend_reg, pend_next;
    logic          fin_reg, fin_next;

    // entries below the top of stack; the top itself lives in tos_reg
    logic [WW-1:0] stack_mem [0:fwbp_pkg::MAX_WORDS-1];
    logic [WW-1:0] rd_data_reg;
    logic          mem_we;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic [WW-1:0] limit;
    logic          over;
    logic [BW-1:0] bit_mask;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign wr_addr  = depth_m1[AW-1:0];
    assign rd_addr  = depth_m2[AW-1:0];

    assign limit    = (word_count > WW'(fwbp_pkg::MAX_WORDS)) ?
                      WW'(fwbp_pkg::MAX_WORDS) : word_count;
    assign over     = !pend_reg && (depth_reg == DW'(0)) && (word_idx_reg >= limit);
    assign bit_mask = BW'(1) << fill_reg[2:0];

    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        tos_next      = tos_reg;
        word_idx_next = word_idx_reg;
        acc_next      = acc_reg;
        fill_next     = fill_reg;
        pend_next     = pend_reg;
        fin_next      = fin_reg;
        mem_we        = 1'b0;
        req_take      = 1'b0;
        res_push      = 1'b0;
        res_data      = '0;
        case (state_reg)
            fwbp_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_take   = 1'b1;
                    state_next = fwbp_pkg::ST_RUN;
                    if (req_restart)
                    begin
                        depth_next    = '0;
                        word_idx_next = '0;
                        acc_next      = '0;
                        fill_next     = '0;
                        pend_next     = 1'b0;
                        fin_next      = 1'b0;
                    end
                end
            end
            fwbp_pkg::ST_RUN:
            begin
                if (fin_reg)
                begin
                    // stream already ended before this request
                    res_data.done_res = 1'b1;
                    if (!res_full)
                    begin
                        res_push   = 1'b1;
                        state_next = fwbp_pkg::ST_IDLE;
                    end
                end
                else if ((fill_reg == FW'(BW)) || over)
                begin
                    res_data.data_byte  = acc_reg;
                    res_data.valid_bits = fill_reg;
                    res_data.last       = over;
                    if (!res_full)
                    begin
                        res_push   = 1'b1;
                        fin_next   = over;
                        acc_next   = '0;
                        fill_next  = '0;
                        state_next = fwbp_pkg::ST_IDLE;
                    end
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                    acc_next  = acc_reg | bit_mask;
                    fill_next = fill_reg + FW'(1);
                end
                else if (depth_reg == DW'(0))
                begin
                    // start the next word
                    tos_next      = word_idx_reg;
                    depth_next    = DW'(1);
                    word_idx_next = word_idx_reg + WW'(1);
                end
                else if (tos_reg < WW'(2))
                begin
                    // leaf: bit 0, and a pending 1 for the second leaf kind
                    fill_next  = fill_reg + FW'(1);
                    pend_next  = (tos_reg == WW'(1));
                    depth_next = depth_m1;
                    if (depth_reg > DW'(1))
                    begin
                        state_next = fwbp_pkg::ST_FETCH;
                    end
                end
                else if (depth_reg < DW'(fwbp_pkg::MAX_WORDS))
                begin
                    // expand: n-1 goes below, n-2 becomes the top
                    mem_we     = 1'b1;
                    tos_next   = tos_reg - WW'(2);
                    depth_next = depth_reg + DW'(1);
                end
                else
                begin
                    // no room for the expansion, entry dropped
                    depth_next = depth_m1;
                    if (depth_reg > DW'(1))
                    begin
                        state_next = fwbp_pkg::ST_FETCH;
                    end
                end
            end
            fwbp_pkg::ST_FETCH:
            begin
                tos_next   = rd_data_reg;
                state_next = fwbp_pkg::ST_RUN;
            end
            default:
            begin
                state_next = fwbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fwbp_pkg::ST_IDLE;
            depth_reg    <= '0;
            word_idx_reg <= '0;
            acc_reg      <= '0;
            fill_reg     <= '0;
            pend_reg     <= 1'b0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            word_idx_reg <= word_idx_next;
            acc_reg      <= acc_next;
            fill_reg     <= fill_next;
            pend_reg     <= pend_next;
            fin_reg      <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= tos_reg - WW'(1);
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    `FWBP_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FW'(BW))
    `FWBP_ASSERT_NOW(a_done_empty, clk, rst_n, res_push && res_data.done_res,
        res_data.valid_bits == FW'(0) && !res_data.last)
    `FWBP_ASSERT_NOW(a_fetch_depth, clk, rst_n, state_reg == fwbp_pkg::ST_FETCH,
        depth_reg != DW'(0))
    `FWBP_ASSERT_NEXT(a_fetch_returns, clk, rst_n, state_reg == fwbp_pkg::ST_FETCH,
        state_reg == fwbp_pkg::ST_RUN)
    `FWBP_ASSERT_NOW(a_depth_bound, clk, rst_n, 1'b1,
        depth_reg <= DW'(fwbp_pkg::MAX_WORDS))

endmodule

// ===== design/fibonacci_word_bit_packer.sv =====
// fibonacci word bit packer: each request returns the next packed byte of the
// stream of fibonacci words W(0) .. W(word_count-1), bits taken LSB-first.
// Every request (push) gets exactly one result (pop). For a request the
// engine works through each generated bit, each word start and each
// expansion in turn, with an extra fetch state after a leaf or a dropped
// entry that leaves the stack non-empty (the stack memory has a registered
// read port), and hands off by taking the request and pushing the result.
// Two-entry queues sit on both sides, so requests and results are taken
// while the engine works. word_count is read at each word start and resets
// to 53; values above 64 act as 64. There is no clearing pass after reset.
// depends on fwbp_pkg, fwbp_req_queue, fwbp_engine and fwbp_res_queue
module fibonacci_word_bit_packer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        restart,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  data_byte,
    output logic [3:0]                  valid_bits,
    output logic                        last,
    output logic                        done_res,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fwbp_pkg::WORD_W-1:0] cfg_data
);

    logic [fwbp_pkg::WORD_W-1:0] word_count_reg;
    logic                        req_valid;
    logic                        req_restart;
    logic                        req_take;
    logic                        res_push;
    logic                        res_full;
    fwbp_pkg::res_t              res_in;
    fwbp_pkg::res_t              res_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= fwbp_pkg::WORD_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            word_count_reg <= cfg_data;
        end
    end

    fwbp_req_queue u_req_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .restart     (restart),
        .full        (full),
        .req_valid   (req_valid),
        .req_restart (req_restart),
        .req_take    (req_take)
    );

    fwbp_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_restart (req_restart),
        .req_take    (req_take),
        .word_count  (word_count_reg),
        .res_push    (res_push),
        .res_data    (res_in),
        .res_full    (res_full)
    );

    fwbp_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign data_byte  = res_out.data_byte;
    assign valid_bits = res_out.valid_bits;
    assign last       = res_out.last;
    assign done_res   = res_out.done_res;

endmodule

// ===== tb/sv/fibonacci_word_bit_packer_tb.sv =====
// self-checking testbench for the fibonacci word bit packer: directed rows, then random phases
// keeps its own model of the bit stream and scores every popped byte against it
// depends on fwbp_pkg and fibonacci_word_bit_packer
module fibonacci_word_bit_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WW           = fwbp_pkg::WORD_W;
    localparam int RANDOM_ITEMS = 650;
    localparam int QUIET_FROM   = 560;
    localparam int NO_CFG       = -1;

    localparam fwbp_pkg::res_t NO_KNOWN      = '0;
    localparam fwbp_pkg::res_t AFTER_END     = {8'h00, 4'd0, 1'b0, 1'b1};
    localparam fwbp_pkg::res_t EMPTY_STREAM  = {8'h00, 4'd0, 1'b1, 1'b0};
    localparam fwbp_pkg::res_t SINGLE_ZERO   = {8'h00, 4'd1, 1'b1, 1'b0};
    localparam fwbp_pkg::res_t TWO_WORD_TAIL = {8'h04, 4'd3, 1'b1, 1'b0};

    typedef struct {
        int             cfg;
        bit             restart;
        bit             typed;
        fwbp_pkg::res_t known;
    } dir_row_t;

    typedef struct {
        bit             typed;
        fwbp_pkg::res_t val;
    } known_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          push = 1'b0;
    logic          full;
    logic          restart = 1'b0;
    logic          empty;
    logic          pop = 1'b0;
    logic [7:0]    data_byte;
    logic [3:0]    valid_bits;
    logic          last;
    logic          done_res;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [WW-1:0] cfg_data = '0;

    // stream model state
    logic [WW-1:0] fib_stack [0:fwbp_pkg::MAX_WORDS-1];
    int unsigned   stack_depth = 0;
    int unsigned   next_word = 0;
    logic [7:0]    acc_byte = '0;
    int unsigned   acc_fill = 0;
    bit            one_pending = 1'b0;
    bit            stream_ended = 1'b0;
    logic [WW-1:0] word_count_q = fwbp_pkg::WORD_COUNT_RESET;

    fwbp_pkg::res_t pending_bytes [$];
    known_t         known_q [$];
    int             mismatches = 0;
    bit             quiet = 1'b0;
    int             pop_stall = 0;

    dir_row_t dir_rows [24] = '{
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b1, 1'b0, NO_KNOWN},
        '{0,      1'b1, 1'b1, EMPTY_STREAM},
        '{NO_CFG, 1'b0, 1'b1, AFTER_END},
        '{NO_CFG, 1'b0, 1'b1, AFTER_END},
        '{1,      1'b1, 1'b1, SINGLE_ZERO},
        '{NO_CFG, 1'b0, 1'b1, AFTER_END},
        '{2,      1'b1, 1'b1, TWO_WORD_TAIL},
        // 32 bits: the fourth byte ends the stream exactly on a boundary
        '{6,      1'b1, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b1, AFTER_END},
        '{127,    1'b1, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        '{64,     1'b0, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        // shrinking the count mid-stream ends it after the current word
        '{3,      1'b0, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        // 19 bits: two full bytes and a partial last one
        '{5,      1'b1, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b0, NO_KNOWN},
        '{NO_CFG, 1'b0, 1'b1, AFTER_END}
    };

    fibonacci_word_bit_packer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .restart    (restart),
        .empty      (empty),
        .pop        (pop),
        .data_byte  (data_byte),
        .valid_bits (valid_bits),
        .last       (last),
        .done_res   (done_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // next byte of the stream, advancing the model state
    function automatic fwbp_pkg::res_t next_packed_byte(input bit restart_req);
        fwbp_pkg::res_t r;
        int unsigned    lim;
        int unsigned    cur;
        r = '0;
        if (restart_req)
        begin
            stack_depth  = 0;
            next_word    = 0;
            acc_byte     = '0;
            acc_fill     = 0;
            one_pending  = 1'b0;
            stream_ended = 1'b0;
        end
        if (stream_ended)
        begin
            r.done_res = 1'b1;
            return r;
        end
        lim = (word_count_q > fwbp_pkg::MAX_WORDS) ? fwbp_pkg::MAX_WORDS : word_count_q;
        while (acc_fill < fwbp_pkg::BYTE_BITS)
        begin
            if (one_pending)
            begin
                one_pending        = 1'b0;
                acc_byte[acc_fill] = 1'b1;
                acc_fill++;
            end
            else if (stack_depth == 0)
            begin
                if (next_word >= lim)
                    break;
                fib_stack[0] = next_word[WW-1:0];
                stack_depth  = 1;
                next_word++;
            end
            else
            begin
                stack_depth--;
                cur = fib_stack[stack_depth];
                if (cur == 0)
                    acc_fill++;
                else if (cur == 1)
                begin
                    acc_fill++;
                    one_pending = 1'b1;
                end
                else if (stack_depth + 2 <= fwbp_pkg::MAX_WORDS)
                begin
                    // lower index on top so W(n-2) comes out first
                    fib_stack[stack_depth]     = WW'(cur - 1);
                    fib_stack[stack_depth + 1] = WW'(cur - 2);
                    stack_depth += 2;
                end
            end
        end
        r.data_byte  = acc_byte;
        r.valid_bits = acc_fill[fwbp_pkg::FILL_W-1:0];
        r.last       = !one_pending && stack_depth == 0 && next_word >= lim;
        if (r.last)
            stream_ended = 1'b1;
        acc_byte = '0;
        acc_fill = 0;
        return r;
    endfunction

    // scoreboard: predict on each request transfer, compare on each result transfer
    always @(posedge clk)
    begin : score
        fwbp_pkg::res_t want;
        fwbp_pkg::res_t seen;
        known_t         kn;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                word_count_q = cfg_data;
            if (push && !full)
            begin
                want = next_packed_byte(restart);
                if (known_q.size() != 0)
                begin
                    kn = known_q.pop_front();
                    if (kn.typed)
                        want = kn.val;
                end
                pending_bytes.push_back(want);
            end
            if (pop && !empty)
            begin
                seen = {data_byte, valid_bits, last, done_res};
                if (pending_bytes.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %h", $time, seen);
                    mismatches++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (seen.data_byte !== want.data_byte)
                    begin
                        $display("%0t data_byte: expected %h, actual %h",
                                 $time, want.data_byte, seen.data_byte);
                        mismatches++;
                    end
                    if (seen.valid_bits !== want.valid_bits)
                    begin
                        $display("%0t valid_bits: expected %0d, actual %0d",
                                 $time, want.valid_bits, seen.valid_bits);
                        mismatches++;
                    end
                    if (seen.last !== want.last)
                    begin
                        $display("%0t last: expected %b, actual %b",
                                 $time, want.last, seen.last);
                        mismatches++;
                    end
                    if (seen.done_res !== want.done_res)
                    begin
                        $display("%0t done_res: expected %b, actual %b",
                                 $time, want.done_res, seen.done_res);
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side: pop stalls in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_stall > 0)
        begin
            pop_stall--;
            pop <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            pop_stall = $urandom_range(0, 2);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    // one request transfer; push stays high into the next call when there is no gap
    task automatic send_req(input bit rs, input bit typed, input fwbp_pkg::res_t known,
                            input int gap);
        known_t kn;
        kn.typed = typed;
        kn.val   = known;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        known_q.push_back(kn);
        push    <= 1'b1;
        restart <= rs;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_word_count(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= WW'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int phase_len;
        int wc;
        bit first_phase;
        sent        = 0;
        first_phase = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg != NO_CFG)
                write_word_count(dir_rows[i].cfg);
            send_req(dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].known, pick_gap());
        end

        while (sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 9))
                0:       wc = 0;
                1:       wc = 64;
                2:       wc = $urandom_range(65, 127);
                3:       wc = 53;
                default: wc = $urandom_range(1, 9);
            endcase
            write_word_count(wc);
            for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++)
            begin
                quiet = (sent >= QUIET_FROM);
                // mid-phase the sender may hold off until every result is back
                if (j == phase_len / 2 && (first_phase || $urandom_range(0, 3) == 0))
                    drain();
                send_req((j == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0),
                         1'b0, NO_KNOWN, pick_gap());
                sent++;
            end
            first_phase = 1'b0;
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
